// File: src/bre_pkg.sv
// Shared types and constants for the bracket repeat expander.
// Holds the channel item structs, controller/datapath command and status structs
// and the character codes. Depends on nothing.
`default_nettype none

package bre_pkg;

    localparam int GROUP_BYTES_W = 64;
    localparam int BYTE_COUNT_W  = 4;

    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [3:0] DIGIT_BASE = 4'd10;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [GROUP_BYTES_W-1:0] group_bytes;
        logic [BYTE_COUNT_W-1:0]  byte_count;
        logic                     run_last;
        logic                     line_done;
        logic                     overflow;
    } out_item_t;

    typedef struct packed {
        logic accept;      // input item taken this cycle: update parse state
        logic load_pass;   // load a pass-through character result
        logic load_empty;  // load the empty end-of-line result
        logic load_group;  // load one repeat of the buffered group
    } dp_cmd_t;

    typedef struct packed {
        logic is_pass;     // item yields one pass-through result
        logic has_reps;    // item closes a group with at least one repeat
        logic line_end;    // item marks the end of the line
        logic rep_last;    // repeat counter is on its last repeat
    } dp_status_t;

endpackage

`default_nettype wire

// File: src/bre_datapath.sv
// Datapath of the bracket repeat expander: parse state, group letter store,
// repeat counter and the result register. Depends on bre_pkg.
`default_nettype none

module bre_datapath #(
    parameter int GROUP_MAX = 8,
    parameter int COUNT_MAX = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  bre_pkg::in_item_t     in_item,
    input  bre_pkg::dp_cmd_t      cmd,
    output bre_pkg::dp_status_t   status,
    output bre_pkg::out_item_t    out_item
);

    localparam int LEN_W  = $clog2(GROUP_MAX + 1);
    localparam int IDX_W  = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
    localparam int CNT_W  = $clog2(COUNT_MAX + 1);
    localparam int PROD_W = CNT_W + 4;

    localparam logic [1:0] MODE_OUTSIDE = 2'd0;
    localparam logic [1:0] MODE_COUNT   = 2'd1;
    localparam logic [1:0] MODE_LETTERS = 2'd2;

    logic [1:0]       mode_reg,  mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic             ovf_reg,   ovf_next;
    logic [CNT_W-1:0] rep_reg,   rep_next;
    logic             le_reg,    le_next;
    logic [7:0]       store_reg [GROUP_MAX];

    bre_pkg::out_item_t out_reg, out_next;

    logic              in_grp, is_digit, digit_used, open_grp, pass_ch;
    logic              close_br, letter, full, flush, store_wr;
    logic [PROD_W-1:0] prod;
    logic [bre_pkg::GROUP_BYTES_W-1:0] packed_bytes;

    always_comb begin
        in_grp     = (mode_reg == MODE_COUNT) || (mode_reg == MODE_LETTERS);
        is_digit   = in_item.ch inside {[bre_pkg::CH_ZERO:bre_pkg::CH_NINE]};
        digit_used = (mode_reg == MODE_COUNT) && is_digit;
        open_grp   = !in_grp && (in_item.ch == bre_pkg::CH_OPEN);
        pass_ch    = !in_grp && (in_item.ch != bre_pkg::CH_OPEN);
        close_br   = in_grp && !digit_used && (in_item.ch == bre_pkg::CH_CLOSE);
        letter     = in_grp && !digit_used && (in_item.ch != bre_pkg::CH_CLOSE);
        full       = !(len_reg < LEN_W'(GROUP_MAX));
        store_wr   = letter && !full;
        flush      = close_br || (in_item.line_end && (in_grp || open_grp));

        // count * 10 + digit, as shifts and adds
        prod = (PROD_W'(count_reg) << 3) + (PROD_W'(count_reg) << 1)
             + PROD_W'(in_item.ch[3:0]);

        count_next = count_reg;
        ovf_next   = ovf_reg;
        len_next   = len_reg;
        mode_next  = mode_reg;

        if (open_grp) begin
            count_next = '0;
            ovf_next   = 1'b0;
            len_next   = '0;
            mode_next  = MODE_COUNT;
        end else if (digit_used) begin
            if (prod > PROD_W'(COUNT_MAX)) begin
                count_next = CNT_W'(COUNT_MAX);
                ovf_next   = 1'b1;
            end else begin
                count_next = prod[CNT_W-1:0];
            end
        end else if (letter) begin
            mode_next = MODE_LETTERS;
            if (full) begin
                ovf_next = 1'b1;
            end else begin
                len_next = len_reg + LEN_W'(1);
            end
        end else if (!in_grp) begin
            mode_next = MODE_OUTSIDE;
        end

        if (flush) begin
            mode_next = MODE_OUTSIDE;
        end

        le_next  = cmd.accept ? in_item.line_end : le_reg;
        rep_next = rep_reg;
        if (cmd.accept) begin
            rep_next = count_next;
        end else if (cmd.load_group) begin
            rep_next = rep_reg - CNT_W'(1);
        end

        status.is_pass  = pass_ch;
        status.has_reps = flush && (len_next != '0) && (count_next != '0);
        status.line_end = in_item.line_end;
        status.rep_last = (rep_reg == CNT_W'(1));
    end

    // Mask bytes beyond the fill level so unwritten entries never show.
    always_comb begin
        packed_bytes = '0;
        for (int i = 0; i < GROUP_MAX; i++) begin
            if (LEN_W'(i) < len_reg) begin
                packed_bytes[8*i +: 8] = store_reg[i];
            end
        end
    end

    always_comb begin
        out_next = out_reg;
        if (cmd.load_pass) begin
            out_next.group_bytes = bre_pkg::GROUP_BYTES_W'(in_item.ch);
            out_next.byte_count  = bre_pkg::BYTE_COUNT_W'(1);
            out_next.run_last    = 1'b1;
            out_next.line_done   = in_item.line_end;
            out_next.overflow    = 1'b0;
        end else if (cmd.load_empty) begin
            out_next.group_bytes = '0;
            out_next.byte_count  = '0;
            out_next.run_last    = 1'b1;
            out_next.line_done   = 1'b1;
            out_next.overflow    = ovf_next;
        end else if (cmd.load_group) begin
            out_next.group_bytes = packed_bytes;
            out_next.byte_count  = bre_pkg::BYTE_COUNT_W'(len_reg);
            out_next.run_last    = status.rep_last;
            out_next.line_done   = status.rep_last && le_reg;
            out_next.overflow    = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_OUTSIDE;
            count_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            rep_reg   <= '0;
            le_reg    <= 1'b0;
        end else begin
            if (cmd.accept) begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                len_reg   <= len_next;
                ovf_reg   <= ovf_next;
            end
            rep_reg <= rep_next;
            le_reg  <= le_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (cmd.accept && store_wr) begin
            store_reg[len_reg[IDX_W-1:0]] <= in_item.ch;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

// File: src/bre_ctrl.sv
// Controller of the bracket repeat expander: input/output handshakes and the
// accept/emit sequencing of group repeats. Depends on bre_pkg.
`default_nettype none

module bre_ctrl (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    input  bre_pkg::dp_status_t  status,
    output bre_pkg::dp_cmd_t     cmd
);

    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_EMIT   = 1'b1;

    logic state_reg,   state_next;
    logic m_valid_reg, m_valid_next;
    logic out_free;

    always_comb begin
        out_free     = !m_valid_reg || m_ready;
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;

        case (state_reg)
            ST_ACCEPT: begin
                s_ready    = out_free;
                cmd.accept = s_valid && out_free;
                if (cmd.accept) begin
                    if (status.is_pass) begin
                        cmd.load_pass = 1'b1;
                        m_valid_next  = 1'b1;
                    end else if (status.has_reps) begin
                        state_next = ST_EMIT;
                    end else if (status.line_end) begin
                        cmd.load_empty = 1'b1;
                        m_valid_next   = 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                // one repeat per free output slot
                if (out_free) begin
                    cmd.load_group = 1'b1;
                    m_valid_next   = 1'b1;
                    if (status.rep_last) begin
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default: begin
                state_next = ST_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: src/bracket_repeat_expander_unit.sv
// Bracket repeat expander: decodes '[' count letters ']' groups in a byte stream.
// Pass-through and empty line-end results appear in the cycle after their item is taken.
// Pass-through, open, count and letter characters are taken whenever the output slot is free;
// an item that closes a group with R repeats holds off the input until all R results are loaded.
// Reset (aresetn, synchronous) clears parse state and handshakes; the letter store is not cleared.
// Depends on bre_pkg, bre_ctrl and bre_datapath.
`default_nettype none

module bracket_repeat_expander_unit #(
    parameter int GROUP_MAX = 8,
    parameter int COUNT_MAX = 64
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  bre_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  wire                 m_ready,
    output bre_pkg::out_item_t  m_item
);

    bre_pkg::dp_cmd_t    cmd;
    bre_pkg::dp_status_t status;

    bre_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bre_datapath #(
        .GROUP_MAX (GROUP_MAX),
        .COUNT_MAX (COUNT_MAX)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_item  (s_item),
        .cmd      (cmd),
        .status   (status),
        .out_item (m_item)
    );

endmodule

`default_nettype wire
